// File: hdl/hc3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3D Hilbert-Peano curve index block.
// No dependencies.
package hc3_pkg;

   localparam int MAX_ORDER_DEF   = 8;
   localparam int MAX_ORDER_LIMIT = 10;
   localparam int COORD_W         = MAX_ORDER_LIMIT;
   localparam int IN_COORD_W      = 8;
   localparam int POS_W           = 24;
   localparam int ORDER_W         = 4;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [POS_W-1:0]   acc;
      logic               neg;
      logic               oor;
   } hc3_stage_type;

   typedef logic [2:0] hc3_corner_type;

   function automatic logic [2:0] hc3_base(input hc3_corner_type c);
      logic [2:0] t;
      case (c)
         3'd0:    t = 3'd0;
         3'd1:    t = 3'd1;
         3'd2:    t = 3'd3;
         3'd3:    t = 3'd2;
         3'd4:    t = 3'd7;
         3'd5:    t = 3'd6;
         3'd6:    t = 3'd4;
         3'd7:    t = 3'd5;
         default: t = 3'd0;
      endcase
      return t;
   endfunction

endpackage

// File: hdl/hc3_level_cell.sv
`timescale 1ns / 1ps
// One curve level: resolves the octant at a fixed level and registers the result.
// Depends on hc3_pkg.
module hc3_level_cell #(
   parameter int LEVEL = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [hc3_pkg::ORDER_W-1:0] order,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hc3_pkg::hc3_stage_type     in_stage,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hc3_pkg::hc3_stage_type     out_stage
);
   import hc3_pkg::*;

   localparam logic [COORD_W-1:0] S_M1   = COORD_W'((1 << LEVEL) - 1);
   localparam logic [COORD_W-1:0] H      = COORD_W'(1 << (LEVEL - 1));
   localparam logic [COORD_W-1:0] H_M1   = H - COORD_W'(1);
   localparam logic [POS_W-1:0]   FULL_M1 = POS_W'((64'd1 << (3 * LEVEL)) - 64'd1);
   localparam int                 SUB_SH = 3 * (LEVEL - 1);

   logic            valid_ff;
   hc3_stage_type   stage_ff;
   hc3_stage_type   stage_in;
   logic            active;
   logic            flip;
   logic            neg1;
   logic [COORD_W-1:0] xm;
   logic [POS_W-1:0]   acc1;
   logic [POS_W-1:0]   ksub;
   logic [1:0]         k;

   assign active   = (ORDER_W'(LEVEL) <= order);
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      flip = in_stage.x[LEVEL-1];
      xm   = flip ? (S_M1 - in_stage.x) : in_stage.x;
      acc1 = in_stage.acc;
      if (flip) begin
         acc1 = in_stage.neg ? (in_stage.acc - FULL_M1) : (in_stage.acc + FULL_M1);
      end
      neg1     = in_stage.neg ^ flip;
      stage_in = in_stage;
      if (!in_stage.y[LEVEL-1] && !in_stage.z[LEVEL-1]) begin
         k = 2'd0;
         stage_in.x = in_stage.z;
         stage_in.y = in_stage.y;
         stage_in.z = xm;
      end else if (!in_stage.y[LEVEL-1]) begin
         k = 2'd1;
         stage_in.x = in_stage.y;
         stage_in.y = xm;
         stage_in.z = in_stage.z - H;
      end else if (in_stage.z[LEVEL-1]) begin
         k = 2'd2;
         stage_in.x = xm;
         stage_in.y = in_stage.y - H;
         stage_in.z = in_stage.z - H;
      end else begin
         k = 2'd3;
         stage_in.x = H_M1 - in_stage.z;
         stage_in.y = H_M1 - xm;
         stage_in.z = in_stage.y - H;
      end
      ksub         = POS_W'(k) << SUB_SH;
      stage_in.acc = neg1 ? (acc1 - ksub) : (acc1 + ksub);
      stage_in.neg = neg1;
      if (!active) begin
         stage_in = in_stage;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// File: hdl/hc3_base_cell.sv
`timescale 1ns / 1ps
// Last cell: order-one corner table, sign fold and result register.
// Depends on hc3_pkg.
module hc3_base_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hc3_pkg::hc3_stage_type     in_stage,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [hc3_pkg::POS_W-1:0]  out_pos,
   output logic                       out_oor
);
   import hc3_pkg::*;

   logic             valid_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             oor_ff;
   logic [POS_W-1:0] t;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      t = POS_W'(hc3_base({in_stage.x[0], in_stage.y[0], in_stage.z[0]}));
      if (in_stage.oor) begin
         pos_in = '0;
      end else if (in_stage.neg) begin
         pos_in = in_stage.acc - t;
      end else begin
         pos_in = in_stage.acc + t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pos_ff <= pos_in;
         oor_ff <= in_stage.oor;
      end
   end

   assign out_valid = valid_ff;
   assign out_pos   = pos_ff;
   assign out_oor   = oor_ff;

endmodule

// File: hdl/hilbert_3d_curve_index.sv
`timescale 1ns / 1ps
// 3D Hilbert-Peano curve index, top level. Uses hc3_pkg, hc3_level_cell, hc3_base_cell.
// Pipeline: one level cell per level MAX_ORDER..2, then the result register.
// Throughput: one transaction per cycle unless rsp stalls; each cell holds one item at a time.
// Bubbles collapse, so a new transaction is taken while a result waits if any cell is empty.
// Reset (synchronous): cells empty, cube_order returns to 1.
module hilbert_3d_curve_index #(
   parameter int MAX_ORDER = hc3_pkg::MAX_ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // csr_tdata: [3:0] cube_order, [7:4] zero
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata,
   // req_tdata: [7:0] coord_0, [15:8] coord_1, [23:16] coord_2
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // rsp_tdata: [23:0] curve_position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // rsp_tuser: [0] out_of_range
   output logic        rsp_tuser
);
   import hc3_pkg::*;

   localparam int NCELL = MAX_ORDER - 1;

   logic [ORDER_W-1:0] cube_order_ff;
   logic [ORDER_W-1:0] eff_order;
   logic [IN_COORD_W-1:0] c0, c1, c2;

   hc3_stage_type st [0:NCELL];
   logic          vld [0:NCELL];
   logic          rdy [0:NCELL];

   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cube_order_ff <= ORDER_W'(1);
      end else if (csr_tvalid && csr_tready) begin
         cube_order_ff <= csr_tdata[ORDER_W-1:0];
      end
   end

   always_comb begin
      eff_order = cube_order_ff;
      if (cube_order_ff == '0) begin
         eff_order = ORDER_W'(1);
      end else if (cube_order_ff > ORDER_W'(MAX_ORDER)) begin
         eff_order = ORDER_W'(MAX_ORDER);
      end
   end

   assign c0 = req_tdata[7:0];
   assign c1 = req_tdata[15:8];
   assign c2 = req_tdata[23:16];

   always_comb begin
      st[0].x   = COORD_W'(c0);
      st[0].y   = COORD_W'(c1);
      st[0].z   = COORD_W'(c2);
      st[0].acc = '0;
      st[0].neg = 1'b0;
      st[0].oor = ((c0 >> eff_order) != '0) || ((c1 >> eff_order) != '0)
               || ((c2 >> eff_order) != '0);
   end

   assign vld[0]     = req_tvalid;
   assign req_tready = rdy[0];

   genvar i;
   generate
      for (i = 0; i < NCELL; i++) begin : g_cell
         hc3_level_cell #(
            .LEVEL(MAX_ORDER - i)
         ) u_level (
            .clock    (clock),
            .reset    (reset),
            .order    (eff_order),
            .in_valid (vld[i]),
            .in_ready (rdy[i]),
            .in_stage (st[i]),
            .out_valid(vld[i+1]),
            .out_ready(rdy[i+1]),
            .out_stage(st[i+1])
         );
      end
   endgenerate

   hc3_base_cell u_base (
      .clock    (clock),
      .reset    (reset),
      .in_valid (vld[NCELL]),
      .in_ready (rdy[NCELL]),
      .in_stage (st[NCELL]),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_pos  (rsp_tdata),
      .out_oor  (rsp_tuser)
   );

endmodule
